### rtl/core/afr_pkg.sv
// Shared types, constants and functions of the addressed frame receiver.
// Used by every module under rtl/core; depends on nothing.
package afr_pkg;

	localparam logic [7:0] START_BYTE = 8'hFF;
	localparam logic [7:0] END_BYTE = 8'hAA;
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'h1021;
	localparam int BUSY_LEN = 6;
	localparam int BUSY_IDX_W = $clog2(BUSY_LEN);
	localparam int QUEUE_DEPTH_DEFAULT = 4;

	typedef enum logic [2:0] {
		ST_IDLE = 3'd0,
		ST_ADDR = 3'd1,
		ST_CMD = 3'd2,
		ST_LEN = 3'd3,
		ST_DATA = 3'd4,
		ST_CRCH = 3'd5,
		ST_CRCL = 3'd6,
		ST_END = 3'd7
	} afr_state_t;

	// Result kinds, encoded as they appear on the out_kind port.
	typedef enum logic [1:0] {
		OUT_PAYLOAD = 2'd0,
		OUT_FRAME_END = 2'd1,
		OUT_BUSY = 2'd2
	} afr_out_kind_t;

	// One entry of the queue between the parser and the result sequencer.
	typedef struct packed {
		afr_out_kind_t op;
		logic [7:0] data;
		logic [7:0] command;
		logic [7:0] length;
		logic crc_ok;
	} afr_cmd_t;

	function automatic logic [15:0] afr_crc_feed(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

	function automatic logic [7:0] afr_busy_byte(input logic [BUSY_IDX_W-1:0] idx);
		logic [7:0] v;
		case (idx)
			3'd0: v = 8'hFF;
			3'd1: v = 8'hFF;
			3'd5: v = 8'hAA;
			default: v = 8'h00;
		endcase
		return v;
	endfunction

endpackage

### rtl/core/afr_front.sv
// Front part of the frame receiver: accepts input items, runs the parser
// state machine and the CRC, and pushes one command per result-causing item.
// Depends on afr_pkg.
module afr_front
	import afr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	input  logic [7:0] cfg_data,
	input  logic       accept,
	input  logic       kind,
	input  logic [7:0] rx_byte,
	output logic       push,
	output afr_cmd_t   push_cmd
);

	afr_state_t state_q, state_d;
	logic [15:0] crc_q, crc_d;
	logic [7:0] count_q, count_d;
	logic [7:0] len_q, len_d;
	logic [7:0] cmd_q, cmd_d;
	logic pending_q, pending_d;
	logic [7:0] addr_q;
	logic byte_in;
	logic [15:0] crc_next;
	logic [7:0] count_inc;

	assign byte_in = accept && !kind;
	assign crc_next = afr_crc_feed(crc_q, rx_byte);
	assign count_inc = count_q + 8'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= '0;
		end else if (cfg_valid) begin
			addr_q <= cfg_data;
		end
	end

	// Next-state logic of the parser.
	always_comb begin
		state_d = state_q;
		if (byte_in) begin
			case (state_q)
				ST_IDLE: begin
					if (!pending_q && rx_byte == START_BYTE) state_d = ST_ADDR;
				end
				ST_ADDR: state_d = (rx_byte == addr_q) ? ST_CMD : ST_IDLE;
				ST_CMD: state_d = ST_LEN;
				ST_LEN: state_d = (rx_byte == 8'd0) ? ST_CRCH : ST_DATA;
				ST_DATA: begin
					if (count_inc == len_q) state_d = ST_CRCH;
				end
				ST_CRCH: state_d = ST_CRCL;
				ST_CRCL: state_d = ST_END;
				ST_END: begin
					if (rx_byte == END_BYTE) state_d = ST_IDLE;
				end
				default: state_d = ST_IDLE;
			endcase
		end
	end

	// Datapath updates and the command handed to the back part.
	always_comb begin
		crc_d = crc_q;
		count_d = count_q;
		len_d = len_q;
		cmd_d = cmd_q;
		pending_d = pending_q;
		push = 1'b0;
		push_cmd = '{op: OUT_PAYLOAD, data: rx_byte, command: cmd_q,
			length: len_q, crc_ok: 1'b0};
		if (accept && kind) begin
			pending_d = 1'b0;
		end else if (byte_in) begin
			case (state_q)
				ST_IDLE: begin
					if (pending_q) begin
						push = 1'b1;
						push_cmd = '{op: OUT_BUSY, data: 8'h00, command: 8'h00,
							length: 8'h00, crc_ok: 1'b0};
					end else if (rx_byte == START_BYTE) begin
						crc_d = CRC_INIT;
						count_d = '0;
					end
				end
				ST_CMD: begin
					cmd_d = rx_byte;
					crc_d = crc_next;
				end
				ST_LEN: begin
					len_d = rx_byte;
					crc_d = crc_next;
					count_d = '0;
				end
				ST_DATA: begin
					crc_d = crc_next;
					count_d = count_inc;
					push = 1'b1;
				end
				ST_CRCH, ST_CRCL: crc_d = crc_next;
				ST_END: begin
					if (rx_byte == END_BYTE) begin
						push = 1'b1;
						push_cmd.op = OUT_FRAME_END;
						push_cmd.data = 8'h00;
						push_cmd.crc_ok = (crc_q == 16'h0000);
						if (crc_q == 16'h0000) pending_d = 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			crc_q <= CRC_INIT;
			count_q <= '0;
			len_q <= '0;
			cmd_q <= '0;
			pending_q <= 1'b0;
		end else begin
			state_q <= state_d;
			crc_q <= crc_d;
			count_q <= count_d;
			len_q <= len_d;
			cmd_q <= cmd_d;
			pending_q <= pending_d;
		end
	end

endmodule

### rtl/core/afr_queue.sv
// Small command queue between the parser and the result sequencer.
// Depends on afr_pkg for the command type.
module afr_queue
	import afr_pkg::*;
#(
	parameter int Depth = QUEUE_DEPTH_DEFAULT
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  afr_cmd_t push_cmd,
	input  logic     pop,
	output afr_cmd_t head,
	output logic     empty,
	output logic     full
);

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
	localparam logic [CntW-1:0] DepthCnt = CntW'(Depth);

	afr_cmd_t mem_q [Depth];
	logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic do_push, do_pop;

	assign empty = (count_q == '0);
	assign full = (count_q == DepthCnt);
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign head = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
			end
			case ({do_push, do_pop})
				2'b10: count_q <= count_q + CntW'(1);
				2'b01: count_q <= count_q - CntW'(1);
				default: ;
			endcase
		end
	end

endmodule

### rtl/core/afr_back.sv
// Back part of the frame receiver: expands queued commands into result items
// (a busy command into six reply bytes) and holds them in the output register.
// Depends on afr_pkg.
module afr_back
	import afr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cmd_valid,
	input  afr_cmd_t   cmd,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] out_kind,
	output logic [7:0] data,
	output logic [7:0] frame_command,
	output logic [7:0] frame_length,
	output logic       crc_ok,
	output logic       last
);

	localparam logic [BUSY_IDX_W-1:0] BusyLast = BUSY_IDX_W'(BUSY_LEN - 1);

	logic [BUSY_IDX_W-1:0] idx_q;
	logic valid_q;
	logic load;
	logic is_busy;
	logic final_beat;
	logic [1:0] kind_q;
	logic [7:0] data_q, command_q, length_q;
	logic ok_q, last_q;

	assign load = !valid_q || !out_stall;
	assign is_busy = (cmd.op == OUT_BUSY);
	assign final_beat = !is_busy || (idx_q == BusyLast);
	assign pop = load && cmd_valid && final_beat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q <= '0;
		end else if (load) begin
			valid_q <= cmd_valid;
			if (cmd_valid) begin
				idx_q <= final_beat ? '0 : idx_q + BUSY_IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && cmd_valid) begin
			kind_q <= cmd.op;
			data_q <= is_busy ? afr_busy_byte(idx_q) : cmd.data;
			command_q <= cmd.command;
			length_q <= cmd.length;
			ok_q <= cmd.crc_ok;
			last_q <= final_beat;
		end
	end

	assign out_valid = valid_q;
	assign out_kind = kind_q;
	assign data = data_q;
	assign frame_command = command_q;
	assign frame_length = length_q;
	assign crc_ok = ok_q;
	assign last = last_q;

endmodule

### rtl/core/addressed_frame_receiver_crc16_core.sv
// Top level of the addressed frame receiver; connects parser, queue and
// result sequencer. Depends on afr_pkg, afr_front, afr_queue and afr_back.
//
// One input item is taken per clock cycle while in_stall is low: the parser
// updates its state and the CRC-16 (one byte through an unrolled eight-step
// shift) in the cycle the item is accepted. Results leave through a
// registered output, one per cycle while out_stall is low, after passing the
// command queue. A busy reply is six bytes long, and the command queue
// (QueueDepth entries) lets input keep flowing meanwhile. in_stall rises
// only when that queue is full. It does not look at the item, so while the
// queue is full every item waits, including those that cause no result
// (address, command, length and CRC bytes, release). The device_address
// register is written through cfg_valid/cfg_data and is always ready.
module addressed_frame_receiver_crc16_core
	import afr_pkg::*;
#(
	parameter int QueueDepth = QUEUE_DEPTH_DEFAULT
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] cfg_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       kind,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] out_kind,
	output logic [7:0] data,
	output logic [7:0] frame_command,
	output logic [7:0] frame_length,
	output logic       crc_ok,
	output logic       last
);

	logic accept;
	logic push, pop, empty, full;
	afr_cmd_t push_cmd, head;

	assign cfg_ready = 1'b1;
	assign in_stall = full;
	assign accept = in_valid && !in_stall;

	afr_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_data (cfg_data),
		.accept   (accept),
		.kind     (kind),
		.rx_byte  (rx_byte),
		.push     (push),
		.push_cmd (push_cmd)
	);

	afr_queue #(
		.Depth(QueueDepth)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_cmd(push_cmd),
		.pop     (pop),
		.head    (head),
		.empty   (empty),
		.full    (full)
	);

	afr_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (!empty),
		.cmd          (head),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_kind     (out_kind),
		.data         (data),
		.frame_command(frame_command),
		.frame_length (frame_length),
		.crc_ok       (crc_ok),
		.last         (last)
	);

endmodule
